// ===== src/tbbm_pkg.sv =====
package tbbm_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_XFORM,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       comp_mac;
		logic       xform_mac;
		logic       clear_acc;
		logic       fold;
		logic [1:0] row;
		logic [1:0] col;
		logic [1:0] k;
		logic       corner;
	} dp_cmd_t;

	localparam logic [1:0] REG_ROW0 = 2'd0;
	localparam logic [1:0] REG_ROW1 = 2'd1;
	localparam logic [1:0] REG_ROW2 = 2'd2;
	localparam logic [1:0] REG_ROW3 = 2'd3;

endpackage

// ===== src/tbbm_if.sv =====
interface tbbm_in_if #(parameter int COORD_WIDTH = 32, parameter int MATRIX_WIDTH = 16);
	logic valid;
	logic ready;
	logic [4*MATRIX_WIDTH-1:0] group_row0;
	logic [4*MATRIX_WIDTH-1:0] group_row1;
	logic [4*MATRIX_WIDTH-1:0] group_row2;
	logic [4*MATRIX_WIDTH-1:0] group_row3;
	logic signed [COORD_WIDTH-1:0] corner_a_x;
	logic signed [COORD_WIDTH-1:0] corner_a_y;
	logic signed [COORD_WIDTH-1:0] corner_a_z;
	logic signed [COORD_WIDTH-1:0] corner_b_x;
	logic signed [COORD_WIDTH-1:0] corner_b_y;
	logic signed [COORD_WIDTH-1:0] corner_b_z;
	logic last_group;
	modport source (output valid, group_row0, group_row1, group_row2, group_row3,
		corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
		last_group, input ready);
	modport sink (input valid, group_row0, group_row1, group_row2, group_row3,
		corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
		last_group, output ready);
endinterface

interface tbbm_out_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] box_min_x;
	logic signed [COORD_WIDTH-1:0] box_min_y;
	logic signed [COORD_WIDTH-1:0] box_min_z;
	logic signed [COORD_WIDTH-1:0] box_max_x;
	logic signed [COORD_WIDTH-1:0] box_max_y;
	logic signed [COORD_WIDTH-1:0] box_max_z;
	modport source (output valid, box_min_x, box_min_y, box_min_z,
		box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z,
		box_max_x, box_max_y, box_max_z, output ready);
endinterface

// ===== src/tbbm_ctrl.sv =====
module tbbm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_ready,
	output tbbm_pkg::dp_cmd_t cmd
);
	import tbbm_pkg::*;

	state_t state_q, state_next;
	logic [1:0] row_q, col_q, k_q;
	logic corner_q, last_q, out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_next = ST_COMP;
			ST_COMP: if (row_q == 2'd2 && col_q == 2'd3 && k_q == 2'd3) state_next = ST_XFORM;
			ST_XFORM: if (k_q == 2'd3) state_next = ST_FOLD;
			ST_FOLD: begin
				if (!(corner_q && row_q == 2'd2)) state_next = ST_XFORM;
				else if (last_q) state_next = ST_EMIT;
				else state_next = ST_IDLE;
			end
			ST_EMIT: if (out_free) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd = '0;
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.k = k_q;
		cmd.corner = corner_q;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_COMP: cmd.comp_mac = 1'b1;
			ST_XFORM: cmd.xform_mac = 1'b1;
			ST_FOLD: cmd.fold = 1'b1;
			ST_EMIT: cmd.clear_acc = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			corner_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			out_valid_q <= (state_q == ST_EMIT && out_free) || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					k_q <= '0;
					corner_q <= 1'b0;
					last_q <= last;
				end
				ST_COMP: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						col_q <= col_q + 2'd1;
						if (col_q == 2'd3) row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
					end
				end
				ST_XFORM: k_q <= k_q + 2'd1;
				ST_FOLD: begin
					if (row_q == 2'd2) begin
						row_q <= 2'd0;
						corner_q <= 1'b1;
					end else begin
						row_q <= row_q + 2'd1;
					end
				end
				ST_EMIT: ;
				default: ;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> last_q) else $error("emit without last");
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q) else $error("result dropped");
endmodule

// ===== src/tbbm_dp.sv =====
module tbbm_dp #(
	parameter int COORD_WIDTH = 32,
	parameter int MATRIX_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  tbbm_pkg::dp_cmd_t cmd,
	input  logic [4*MATRIX_WIDTH-1:0] outer_row [4],
	input  logic [4*MATRIX_WIDTH-1:0] grp_in [4],
	input  logic signed [COORD_WIDTH-1:0] crn_in [6],
	output logic signed [COORD_WIDTH-1:0] min_out [3],
	output logic signed [COORD_WIDTH-1:0] max_out [3]
);
	import tbbm_pkg::*;

	localparam int MW = MATRIX_WIDTH;
	localparam int CW = 2*MW + 2;            // composite entry width
	localparam int RS = 2*(MW/2);            // fraction bits dropped
	localparam int PW = CW + COORD_WIDTH;    // product width
	localparam int AW = PW + 2;              // accumulator width
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic [4*MW-1:0] grp_q [4];
	logic signed [COORD_WIDTH-1:0] crn_q [6];
	logic signed [CW-1:0] comp_q [3][4];
	logic signed [AW-1:0] acc_q;
	logic signed [COORD_WIDTH-1:0] min_q [3];
	logic signed [COORD_WIDTH-1:0] max_q [3];

	logic signed [MW-1:0] ea, eb;
	logic signed [2*MW-1:0] mprod;
	logic signed [CW-1:0] ce;
	logic [2:0] vidx;
	logic signed [COORD_WIDTH-1:0] vj;
	logic signed [PW-1:0] xprod;
	logic signed [AW-1:0] rnd, shr;
	logic signed [COORD_WIDTH-1:0] res;

	always_comb begin
		ea = outer_row[cmd.row][(3-cmd.k)*MW +: MW];
		eb = grp_q[cmd.k][(3-cmd.col)*MW +: MW];
		mprod = ea * eb;
		ce = comp_q[cmd.row][cmd.k];
		vidx = cmd.corner ? 3'd3 + {1'b0, cmd.k} : {1'b0, cmd.k};
		if (cmd.k == 2'd3) vj = COORD_WIDTH'(1) <<< (COORD_WIDTH/2);
		else vj = crn_q[vidx];
		xprod = ce * vj;
		rnd = acc_q + (AW'(1) <<< (RS-1));
		shr = rnd >>> RS;
		if (shr > AW'(CMAX)) res = CMAX;
		else if (shr < AW'(CMIN)) res = CMIN;
		else res = shr[COORD_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			grp_q <= grp_in;
			crn_q <= crn_in;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 4; j++) comp_q[i][j] <= '0;
		end
		if (cmd.comp_mac)
			comp_q[cmd.row][cmd.col] <= comp_q[cmd.row][cmd.col] + CW'(mprod);
		if (cmd.xform_mac)
			acc_q <= ((cmd.k == 2'd0) ? '0 : acc_q) + AW'(xprod);
		if (cmd.clear_acc) begin
			min_out <= min_q;
			max_out <= max_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= CMAX;
				max_q[i] <= CMIN;
			end
		end else if (cmd.clear_acc) begin
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= CMAX;
				max_q[i] <= CMIN;
			end
		end else if (cmd.fold) begin
			if (res < min_q[cmd.row]) min_q[cmd.row] <= res;
			if (res > max_q[cmd.row]) max_q[cmd.row] <= res;
		end
	end
endmodule

// ===== src/transformed_bounding_box_merge.sv =====
// From accepting an item: 48 matrix product steps, then six corner rows of four
// multiply-accumulate steps and one fold step each, then, for an item marked last, a
// load of the output register. A new item is taken only in the idle state; a result
// still waiting in the output register holds off the next emit, while the next item
// is taken.
// Asynchronous active-low reset loads the outer transform reset rows and
// clears the running extremes to the ends of the coordinate range.
module transformed_bounding_box_merge #(
	parameter int COORD_WIDTH = 32,
	parameter int MATRIX_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	tbbm_in_if.sink  in_ch,
	tbbm_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import tbbm_pkg::*;

	logic [4*MATRIX_WIDTH-1:0] outer_q [4];
	logic [4*MATRIX_WIDTH-1:0] grp [4];
	logic signed [COORD_WIDTH-1:0] crn [6];
	logic signed [COORD_WIDTH-1:0] mn [3];
	logic signed [COORD_WIDTH-1:0] mx [3];
	dp_cmd_t cmd;
	logic [1:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:3];
	assign prdata = 64'(outer_q[ridx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q[0] <= (4*MATRIX_WIDTH)'(64'h0000_0001_0000_0000);
			outer_q[1] <= (4*MATRIX_WIDTH)'(64'h0000_0000_0001_0000);
			outer_q[2] <= (4*MATRIX_WIDTH)'(64'h0000_0000_0000_0100);
			outer_q[3] <= (4*MATRIX_WIDTH)'(64'h0000_0000_0000_0001);
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			unique case (ridx)
				REG_ROW0: outer_q[0] <= pwdata[4*MATRIX_WIDTH-1:0];
				REG_ROW1: outer_q[1] <= pwdata[4*MATRIX_WIDTH-1:0];
				REG_ROW2: outer_q[2] <= pwdata[4*MATRIX_WIDTH-1:0];
				REG_ROW3: outer_q[3] <= pwdata[4*MATRIX_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign grp[0] = in_ch.group_row0;
	assign grp[1] = in_ch.group_row1;
	assign grp[2] = in_ch.group_row2;
	assign grp[3] = in_ch.group_row3;
	assign crn[0] = in_ch.corner_a_x;
	assign crn[1] = in_ch.corner_a_y;
	assign crn[2] = in_ch.corner_a_z;
	assign crn[3] = in_ch.corner_b_x;
	assign crn[4] = in_ch.corner_b_y;
	assign crn[5] = in_ch.corner_b_z;

	tbbm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .last(in_ch.last_group),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd)
	);

	tbbm_dp #(.COORD_WIDTH(COORD_WIDTH), .MATRIX_WIDTH(MATRIX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .outer_row(outer_q), .grp_in(grp),
		.crn_in(crn), .min_out(mn), .max_out(mx)
	);

	assign out_ch.box_min_x = mn[0];
	assign out_ch.box_min_y = mn[1];
	assign out_ch.box_min_z = mn[2];
	assign out_ch.box_max_x = mx[0];
	assign out_ch.box_max_y = mx[1];
	assign out_ch.box_max_z = mx[2];
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import tbbm_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;

	tbbm_in_if in_ch ();
	tbbm_out_if out_ch ();

	transformed_bounding_box_merge dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	typedef struct {
		logic [63:0] row [4];
		logic signed [31:0] ca [3];
		logic signed [31:0] cb [3];
		logic last;
	} group_t;

	// Six extremes packed min x,y,z then max x,y,z, field 0 lowest.
	typedef logic [191:0] box_t;

	localparam longint COORD_HI = 64'sd2147483647;
	localparam longint COORD_LO = -64'sd2147483648;
	localparam int SETTLE_CYCLES = 80;

	logic [63:0] outer_model [4];
	longint lo_acc [3];
	longint hi_acc [3];
	box_t box_queue [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_left = 0;
	string field_names [6] = '{"box_min_x", "box_min_y", "box_min_z",
		"box_max_x", "box_max_y", "box_max_z"};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic longint mat_entry(logic [63:0] row, int col);
		logic signed [15:0] e;
		e = row[(3 - col) * 16 +: 16];
		return longint'(e);
	endfunction

	function automatic longint round_sat(logic signed [127:0] acc);
		logic signed [127:0] r;
		r = (acc + 128'sd32768) >>> 16;
		if (r > 128'(COORD_HI))
			return COORD_HI;
		if (r < $signed(128'(COORD_LO)))
			return COORD_LO;
		return longint'(r);
	endfunction

	task automatic clear_extremes();
		for (int i = 0; i < 3; i++) begin
			lo_acc[i] = COORD_HI;
			hi_acc[i] = COORD_LO;
		end
	endtask

	// Folds one accepted group into the running extremes, queueing a box on the last one.
	task automatic fold_group(group_t g);
		longint comp [3][4];
		logic signed [127:0] acc, a, b;
		longint v [4];
		longint r;
		box_t bx;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 4; j++) begin
				comp[i][j] = 0;
				for (int k = 0; k < 4; k++)
					comp[i][j] += mat_entry(outer_model[i], k) * mat_entry(g.row[k], j);
			end
		for (int c = 0; c < 2; c++) begin
			for (int j = 0; j < 3; j++)
				v[j] = c == 0 ? longint'(g.ca[j]) : longint'(g.cb[j]);
			v[3] = 65536;
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 4; j++) begin
					a = comp[i][j];
					b = v[j];
					acc += a * b;
				end
				r = round_sat(acc);
				if (r < lo_acc[i])
					lo_acc[i] = r;
				if (r > hi_acc[i])
					hi_acc[i] = r;
			end
		end
		if (g.last) begin
			for (int i = 0; i < 3; i++) begin
				bx[i * 32 +: 32] = lo_acc[i][31:0];
				bx[(i + 3) * 32 +: 32] = hi_acc[i][31:0];
			end
			box_queue.insert(box_queue.size(), bx);
			clear_extremes();
		end
	endtask

	// Receiver: random backpressure, or a long hold while stall_left counts down.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			box_t got, want;
			got = {out_ch.box_max_z, out_ch.box_max_y, out_ch.box_max_x,
				out_ch.box_min_z, out_ch.box_min_y, out_ch.box_min_x};
			if (box_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected box %h", $time, got);
			end else begin
				want = box_queue.pop_front();
				for (int i = 0; i < 6; i++)
					if (got[i * 32 +: 32] !== want[i * 32 +: 32]) begin
						errors++;
						$display("%0t: %s expected %h actual %h", $time, field_names[i],
							want[i * 32 +: 32], got[i * 32 +: 32]);
					end
			end
		end
	end

	task automatic send_group(group_t g);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.group_row0 <= g.row[0];
		in_ch.group_row1 <= g.row[1];
		in_ch.group_row2 <= g.row[2];
		in_ch.group_row3 <= g.row[3];
		in_ch.corner_a_x <= g.ca[0];
		in_ch.corner_a_y <= g.ca[1];
		in_ch.corner_a_z <= g.ca[2];
		in_ch.corner_b_x <= g.cb[0];
		in_ch.corner_b_y <= g.cb[1];
		in_ch.corner_b_z <= g.cb[2];
		in_ch.last_group <= g.last;
		do @(posedge clk); while (!in_ch.ready);
		fold_group(g);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (box_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_outer(logic [1:0] idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		outer_model[idx] = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== val) begin
			errors++;
			$display("%0t: outer_row%0d expected %h actual %h", $time, idx, val, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_outer(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
		logic [63:0] r3);
		write_outer(REG_ROW0, r0);
		write_outer(REG_ROW1, r1);
		write_outer(REG_ROW2, r2);
		write_outer(REG_ROW3, r3);
	endtask

	function automatic logic [15:0] rand_entry();
		unique case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(1024)) - 512);
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		unique case ($urandom_range(4))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
		endcase
	endfunction

	function automatic group_t rand_group(logic last);
		group_t g;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				g.row[r][(3 - c) * 16 +: 16] = rand_entry();
		for (int j = 0; j < 3; j++) begin
			g.ca[j] = rand_coord();
			g.cb[j] = rand_coord();
		end
		g.last = last;
		return g;
	endfunction

	function automatic group_t fixed_group(logic [63:0] r0, logic [31:0] a, logic [31:0] b,
		logic last);
		group_t g;
		g.row[0] = r0;
		g.row[1] = 64'h0000_0100_0000_0000;
		g.row[2] = 64'h0000_0000_0100_0000;
		g.row[3] = 64'h0000_0000_0000_0100;
		for (int j = 0; j < 3; j++) begin
			g.ca[j] = a;
			g.cb[j] = b;
		end
		g.last = last;
		return g;
	endfunction

	task automatic test_directed();
		group_t g;
		// Identity group, ordered and swapped corners.
		send_group(fixed_group(64'h0100_0000_0000_0000, 32'hffff_0000, 32'h0001_0000, 1'b1));
		send_group(fixed_group(64'h0100_0000_0000_0000, 32'h0003_8000, 32'hfffc_8000, 1'b1));
		// Extreme corners through identity and through a doubled row, which saturates.
		send_group(fixed_group(64'h0100_0000_0000_0000, 32'h7fffffff, 32'h80000000, 1'b1));
		send_group(fixed_group(64'h0200_0000_0000_0000, 32'h7fffffff, 32'h80000000, 1'b1));
		send_group(fixed_group(64'h7fff_7fff_7fff_7fff, 32'h7fffffff, 32'h7fffffff, 1'b1));
		send_group(fixed_group(64'h8000_8000_8000_8000, 32'h7fffffff, 32'h80000000, 1'b1));
		// Half-LSB rounding and the zero matrix.
		send_group(fixed_group(64'h0080_0000_0000_0000, 32'h0000_0001, 32'hffff_ffff, 1'b1));
		send_group(fixed_group(64'h0000_0000_0000_0000, 32'h1234_5678, 32'h8765_4321, 1'b1));
		// A list of several groups where only the final one produces a box.
		for (int i = 0; i < 5; i++)
			send_group(rand_group(i == 4));
		g = rand_group(1'b1);
		for (int r = 0; r < 4; r++)
			g.row[r] = 64'hffff_ffff_ffff_ffff;
		send_group(g);
		drain();
	endtask

	task automatic test_random(int n_items);
		int left, len;
		left = n_items;
		while (left > 0) begin
			len = $urandom_range(3) == 0 ? $urandom_range(8, 1) : $urandom_range(2, 1);
			for (int i = 0; i < len && left > 0; i++, left--)
				send_group(rand_group(i == len - 1 || left == 1));
		end
		drain();
	endtask

	// The receiver blocks while single-group lists keep coming, so the block backs up.
	task automatic test_backpressure();
		stall_left = 600;
		for (int i = 0; i < 12; i++)
			send_group(rand_group(1'b1));
		drain();
	endtask

	task automatic test_outer_settings();
		load_outer(64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000,
			64'h7fff_8000_7fff_8000, 64'h8000_7fff_8000_7fff);
		test_random(60);
		load_outer(64'h0, 64'h0, 64'h0, 64'h0);
		test_random(30);
		load_outer(64'hffff_ffff_ffff_ffff, 64'($urandom), {$urandom, $urandom},
			{$urandom, $urandom});
		test_random(60);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.group_row0 = '0;
		in_ch.group_row1 = '0;
		in_ch.group_row2 = '0;
		in_ch.group_row3 = '0;
		in_ch.corner_a_x = '0;
		in_ch.corner_a_y = '0;
		in_ch.corner_a_z = '0;
		in_ch.corner_b_x = '0;
		in_ch.corner_b_y = '0;
		in_ch.corner_b_z = '0;
		in_ch.last_group = 1'b0;
		out_ch.ready = 1'b0;
		outer_model[0] = 64'h1_0000_0000;
		outer_model[1] = 64'h1_0000;
		outer_model[2] = 64'h100;
		outer_model[3] = 64'h1;
		clear_extremes();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 47;
		test_directed();
		test_random(500);
		test_backpressure();
		test_outer_settings();

		send_idle_pct = 47;
		recv_idle_pct = 15;
		load_outer({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		test_random(550);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_outer(64'h1_0000_0000, 64'h1_0000, 64'h100, 64'h1);
		test_random(600);

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/tbbm_pkg.sv
src/tbbm_if.sv
src/tbbm_ctrl.sv
src/tbbm_dp.sv
src/transformed_bounding_box_merge.sv
tb/tb_top.sv
